// ===== hdl/cgfm_pkg.sv =====
// Package for the cross gradient focus map: widths, register codes, result bundle, gradient math.
`default_nettype none

package cgfm_pkg;

	// Field widths
	localparam int PIX_W   = 8;
	localparam int ROW_W   = 16;
	localparam int COL_W   = 10;
	localparam int GRAD_W  = 8;
	localparam int WCFG_W  = 11;
	localparam int HCFG_W  = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	// Defaults
	localparam int DEFAULT_MAX_WIDTH = 1024;
	localparam int QUEUE_DEPTH       = 4;

	localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [HCFG_W-1:0] HEIGHT_RESET = 16'd480;
	localparam logic [GRAD_W-1:0] GRAD_MAX     = 8'd255;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cgfm_reg_t;

	// Up to three results caused by one input pixel at (row, col)
	typedef struct packed {
		logic              emit_center;  // gradient for (row-1, col-1)
		logic              emit_right;   // right border for (row-1, col)
		logic              emit_bottom;  // bottom border for (row, col)
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [GRAD_W-1:0] grad;
	} cgfm_bundle_t;

	function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// |up - down| + |right - left|, saturated
	function automatic logic [GRAD_W-1:0] cross_grad(input logic [PIX_W-1:0] up,
		input logic [PIX_W-1:0] down, input logic [PIX_W-1:0] right,
		input logic [PIX_W-1:0] left);
		logic [PIX_W:0] sum;
		sum = {1'b0, abs_diff(up, down)} + {1'b0, abs_diff(right, left)};
		return sum[PIX_W] ? GRAD_MAX : sum[PIX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/cgfm_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module cgfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cgfm_scan.sv =====
// Raster counters, line stores with forwarding, and the gradient stage.
`default_nettype none

module cgfm_scan
	import cgfm_pkg::*;
#(
	parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [PIX_W-1:0]  pixel,
	input  wire logic [WCFG_W-1:0] width_cfg,
	input  wire logic [HCFG_W-1:0] height_cfg,
	output logic                   pending,
	output logic                   push,
	output cgfm_bundle_t           bundle
);

	localparam int AW = $clog2(MAX_WIDTH);

	// Raster state
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] left_q;

	// Effective limits
	logic [AW-1:0]    wlast;
	logic [ROW_W-1:0] hlast;

	// Address generation
	logic [AW-1:0] idx, col_m1, col_m2;
	logic          col_end, row_end;

	// Stage 1
	logic              valid_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W-1:0]  col_s1;
	logic [PIX_W-1:0]  left_s1;
	logic [AW-1:0]     idx_s1;
	logic              e_center_s1, e_right_s1, e_bottom_s1, grad_en_s1;
	logic              fwd_ra_a_s1, fwd_ra_b_s1, fwd_rt_a_s1, fwd_rt_b_s1;
	logic [PIX_W-1:0]  ra_fwd_s1, rt_fwd_s1;

	// Line store read data
	logic [PIX_W-1:0] ra_rd_a, ra_rd_b, rt_rd_a, rt_rd_b;
	logic [PIX_W-1:0] right_px, above_idx_px, up_px, left_px;
	logic [GRAD_W-1:0] grad;

	// Clamp the configured frame size
	always_comb begin
		if (width_cfg < 11'd3) begin
			wlast = AW'(2);
		end else if (32'(width_cfg) > 32'(MAX_WIDTH)) begin
			wlast = AW'(MAX_WIDTH - 1);
		end else begin
			wlast = AW'(width_cfg - 11'd1);
		end
		hlast = (height_cfg < 16'd3) ? 16'd2 : (height_cfg - 16'd1);
	end

	// Held-back pixel goes into the line stores one column late
	assign idx     = (col_q == '0) ? wlast : (col_q - AW'(1));
	assign col_m1  = col_q - AW'(1);
	assign col_m2  = col_q - AW'(2);
	assign col_end = (col_q >= wlast);
	assign row_end = (row_q >= hlast);

	// Counters and stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				left_q <= pixel;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : (row_q + 16'd1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	// Stage 1 payload, plus bypass of the write retiring on the same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1      <= row_q;
			col_s1      <= COL_W'(col_q);
			left_s1     <= left_q;
			idx_s1      <= idx;
			e_center_s1 <= (row_q != '0) && (col_q != '0);
			e_right_s1  <= (row_q != '0) && col_end;
			e_bottom_s1 <= row_end;
			grad_en_s1  <= (row_q >= 16'd2) && (col_q >= AW'(2));
			fwd_ra_a_s1 <= valid_s1 && (col_q == idx_s1);
			fwd_ra_b_s1 <= valid_s1 && (idx == idx_s1);
			fwd_rt_a_s1 <= valid_s1 && (col_m1 == idx_s1);
			fwd_rt_b_s1 <= valid_s1 && (col_m2 == idx_s1);
			ra_fwd_s1   <= left_s1;
			rt_fwd_s1   <= above_idx_px;
		end
	end

	// Row above: read at col and at the write index
	cgfm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_above (
		.clk     (clk),
		.we      (valid_s1),
		.waddr   (idx_s1),
		.wdata   (left_s1),
		.re      (accept),
		.raddr_a (col_q),
		.raddr_b (idx),
		.rdata_a (ra_rd_a),
		.rdata_b (ra_rd_b)
	);

	// Row two above: read at col-1 and col-2
	cgfm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_two_above (
		.clk     (clk),
		.we      (valid_s1),
		.waddr   (idx_s1),
		.wdata   (above_idx_px),
		.re      (accept),
		.raddr_a (col_m1),
		.raddr_b (col_m2),
		.rdata_a (rt_rd_a),
		.rdata_b (rt_rd_b)
	);

	// Window values after bypass
	assign right_px     = fwd_ra_a_s1 ? ra_fwd_s1 : ra_rd_a;
	assign above_idx_px = fwd_ra_b_s1 ? ra_fwd_s1 : ra_rd_b;
	assign up_px        = fwd_rt_a_s1 ? rt_fwd_s1 : rt_rd_a;
	assign left_px      = fwd_rt_b_s1 ? rt_fwd_s1 : rt_rd_b;

	assign grad = grad_en_s1 ? cross_grad(up_px, left_s1, right_px, left_px) : '0;

	// Hand results to the queue
	assign pending             = valid_s1;
	assign push                = valid_s1 && (e_center_s1 || e_right_s1 || e_bottom_s1);
	assign bundle.emit_center  = e_center_s1;
	assign bundle.emit_right   = e_right_s1;
	assign bundle.emit_bottom  = e_bottom_s1;
	assign bundle.row          = row_s1;
	assign bundle.col          = col_s1;
	assign bundle.grad         = grad;

	// Column counter stays inside the line stores
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(MAX_WIDTH))
		else $error("column counter beyond line store depth");

	// Stage 1 holds one transaction for exactly one cycle
	a_s1_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(accept))
		else $error("stage 1 valid without an accepted transaction");

endmodule

`default_nettype wire

// ===== hdl/cgfm_out_queue.sv =====
// Result queue: buffers result bundles and serializes them onto the output channel.
`default_nettype none

module cgfm_out_queue
	import cgfm_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cgfm_bundle_t  bundle,
	input  wire logic          pending,
	output logic               room,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [ROW_W-1:0]   out_row,
	output logic [COL_W-1:0]   out_col,
	output logic [GRAD_W-1:0]  gradient,
	output logic               last_of_item
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cgfm_bundle_t   mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic [2:0]     done_q;

	cgfm_bundle_t   head;
	logic [2:0]     remaining, cur;
	logic           is_last, take, pop;
	logic [CW:0]    fill;

	// Room counts the bundle still in the gradient stage
	assign fill = {1'b0, count_q} + (CW+1)'(pending);
	assign room = fill < (CW+1)'(QUEUE_DEPTH);

	assign head      = mem_q[rd_ptr_q];
	assign remaining = {head.emit_center, head.emit_right, head.emit_bottom} & ~done_q;

	// Pick the next result of the head bundle
	always_comb begin
		cur = 3'b000;
		priority if (remaining[2]) begin
			cur = 3'b100;
		end else if (remaining[1]) begin
			cur = 3'b010;
		end else if (remaining[0]) begin
			cur = 3'b001;
		end else begin
			cur = 3'b000;
		end
	end

	assign is_last   = (remaining & ~cur) == 3'b000;
	assign out_valid = (count_q != '0);
	assign take      = out_valid && out_ready;
	assign pop       = take && is_last;

	// Result fields of the selected entry
	always_comb begin
		priority if (cur[2]) begin
			out_row  = head.row - 16'd1;
			out_col  = head.col - 10'd1;
			gradient = head.grad;
		end else if (cur[1]) begin
			out_row  = head.row - 16'd1;
			out_col  = head.col;
			gradient = '0;
		end else begin
			out_row  = head.row;
			out_col  = head.col;
			gradient = '0;
		end
	end
	assign last_of_item = is_last;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= bundle;
		end
	end

	// Pointers, fill count and per-bundle progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			done_q   <= 3'b000;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : (wr_ptr_q + PW'(1));
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : (rd_ptr_q + PW'(1));
				done_q   <= 3'b000;
			end else if (take) begin
				done_q <= done_q | cur;
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Queue plus gradient stage never exceed the queue depth
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= (CW+1)'(QUEUE_DEPTH))
		else $error("result queue overflow");

	// A shown result always comes from a bundle with work left
	a_head_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (remaining != 3'b000))
		else $error("queue head has no result left");

endmodule

`default_nettype wire

// ===== hdl/cross_gradient_focus_map.sv =====
// Top level of the cross gradient focus map: configuration registers and block wiring.
//
//  channel   direction  handshake              payload
//  pixel     in         in_valid / in_ready    pixel
//  result    out        out_valid / out_ready  out_row, out_col, gradient, last_of_item
//  config    in         cfg_write_en           cfg_index, cfg_data
//
// One pixel per clock is taken while the queue has room; each pixel's results enter the queue
// at the edge after its transaction and show on the output once older results have gone.
// The output port moves one result per clock while out_ready is high; one result per pixel
// on average; pixels ending a row give two, the last pixel of a frame three, in a 4-entry queue.
// in_ready drops only when the queue plus the gradient stage hold 4 bundles.
// Reset: row and column 0, width 640, height 480; line stores are not cleared.
`default_nettype none

module cross_gradient_focus_map
	import cgfm_pkg::*;
#(
	parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [PIX_W-1:0]     pixel,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [ROW_W-1:0]          out_row,
	output logic [COL_W-1:0]          out_col,
	output logic [GRAD_W-1:0]         gradient,
	output logic                      last_of_item
);

	logic [WCFG_W-1:0] width_q;
	logic [HCFG_W-1:0] height_q;
	logic              in_accept, pending, push, room;
	cgfm_bundle_t      bundle;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write_en) begin
			unique case (cgfm_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WCFG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HCFG_W-1:0];
				default:          ;
			endcase
		end
	end

	assign in_ready  = room;
	assign in_accept = in_valid && in_ready;

	cgfm_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.pixel      (pixel),
		.width_cfg  (width_q),
		.height_cfg (height_q),
		.pending    (pending),
		.push       (push),
		.bundle     (bundle)
	);

	cgfm_out_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.bundle       (bundle),
		.pending      (pending),
		.room         (room),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_row      (out_row),
		.out_col      (out_col),
		.gradient     (gradient),
		.last_of_item (last_of_item)
	);

endmodule

`default_nettype wire

// ===== test/cross_gradient_focus_map_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the cross gradient focus map: directed frames, then random traffic.
module cross_gradient_focus_map_tb;
	import cgfm_pkg::*;

	localparam int MAX_W         = DEFAULT_MAX_WIDTH;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 20;
	localparam int RANDOM_ITEMS  = 400;
	localparam int CYCLE_LIMIT   = 6_000_000;

	// One result transaction as seen on the output channel
	typedef struct packed {
		logic [ROW_W-1:0]  out_row;
		logic [COL_W-1:0]  out_col;
		logic [GRAD_W-1:0] gradient;
		logic              last_of_item;
	} grad_result_t;

	typedef enum logic {STIM_CONFIG, STIM_PIXEL} stim_kind_e;

	// Directed table entry; typed results replace the predicted ones when present
	typedef struct packed {
		stim_kind_e              kind;
		cgfm_reg_t               reg_sel;
		logic [CFG_W-1:0]        data;
		logic                    has_typed;
		logic [1:0]              n_typed;
		grad_result_t [2:0]      typed_res;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [PIX_W-1:0]     pixel;
	logic                 out_valid;
	logic                 out_ready;
	logic [ROW_W-1:0]     out_row;
	logic [COL_W-1:0]     out_col;
	logic [GRAD_W-1:0]    gradient;
	logic                 last_of_item;

	// Predictor state
	logic [PIX_W-1:0] line_above [MAX_W];
	logic [PIX_W-1:0] line_two_above [MAX_W];
	logic [PIX_W-1:0] held_pixel;
	int               cur_row;
	int               cur_col;
	int               cfg_width;
	int               cfg_height;

	grad_result_t pixel_results[$];
	grad_result_t grad_expected[$];
	grad_result_t typed_results [3];
	int           typed_count = -1;
	stim_row_t    directed_rows[$];

	bit tx_gaps_on   = 1'b1;
	bit rx_stalls_on = 1'b1;
	int fault_count  = 0;
	int cycle_count;
	int random_sent  = 0;

	cross_gradient_focus_map dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel       (pixel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_row     (out_row),
		.out_col     (out_col),
		.gradient    (gradient),
		.last_of_item(last_of_item)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int focus_width();
		return (cfg_width < 3) ? 3 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
	endfunction

	function automatic int focus_height();
		return (cfg_height < 3) ? 3 : cfg_height;
	endfunction

	// Mostly no gap, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		int roll;
		roll = $urandom_range(0, 7);
		if (roll == 0) return '0;
		if (roll == 1) return '1;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	function automatic grad_result_t res(input int r, input int c, input int g, input bit l);
		return '{out_row: ROW_W'(r), out_col: COL_W'(c), gradient: GRAD_W'(g), last_of_item: l};
	endfunction

	// Predictor: results for one accepted pixel, then state update
	function automatic void advance_focus_map(input logic [PIX_W-1:0] pix);
		int w, h, r, c, g, idx;
		int up, down, right_px, left_px;
		w = focus_width();
		h = focus_height();
		r = cur_row;
		c = cur_col;
		pixel_results.delete();
		if (r >= 1 && c >= 1) begin
			g = 0;
			if (r >= 2 && c >= 2) begin
				up       = line_two_above[c-1];
				down     = held_pixel;
				right_px = line_above[c];
				left_px  = line_two_above[c-2];
				g = ((up > down) ? up - down : down - up)
					+ ((right_px > left_px) ? right_px - left_px : left_px - right_px);
				if (g > 255) g = 255;
			end
			pixel_results.push_back(res(r - 1, c - 1, g, 1'b0));
		end
		// right border of the row above
		if (r >= 1 && c >= w - 1)
			pixel_results.push_back(res(r - 1, c, 0, 1'b0));
		// bottom border
		if (r >= h - 1)
			pixel_results.push_back(res(r, c, 0, 1'b0));
		if (pixel_results.size() > 0)
			pixel_results[pixel_results.size()-1].last_of_item = 1'b1;

		// held pixel enters the line stores one step late
		idx = (c == 0) ? w - 1 : c - 1;
		line_two_above[idx] = line_above[idx];
		line_above[idx] = held_pixel;
		held_pixel = pix;

		if (c >= w - 1) begin
			cur_col = 0;
			cur_row = (r >= h - 1) ? 0 : r + 1;
		end else begin
			cur_col = c + 1;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction
	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		int gap;
		int i;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= pix;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		advance_focus_map(pix);
		if (typed_count >= 0) begin
			for (i = 0; i < typed_count; i++) grad_expected.push_back(typed_results[i]);
			typed_count = -1;
		end else begin
			foreach (pixel_results[i]) grad_expected.push_back(pixel_results[i]);
		end
		@(negedge clk);
	endtask

	// Pixels until the frame counters wrap to the origin
	task automatic send_frame();
		do send_pixel(random_pixel());
		while (cur_row != 0 || cur_col != 0);
	endtask

	// Stop sending and let every expected result drain
	task automatic settle();
		in_valid <= 1'b0;
		while (grad_expected.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cgfm_reg_t sel, input logic [CFG_W-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index    <= sel;
		cfg_data     <= val;
		@(posedge clk);
		if (sel == REG_IMAGE_WIDTH) cfg_width = int'(val[WCFG_W-1:0]);
		else cfg_height = int'(val[HCFG_W-1:0]);
		@(negedge clk);
		cfg_write_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_cfg(input cgfm_reg_t sel, input logic [CFG_W-1:0] val);
		stim_row_t row;
		row = '0;
		row.kind    = STIM_CONFIG;
		row.reg_sel = sel;
		row.data    = val;
		directed_rows.push_back(row);
	endtask

	task automatic add_pix(input logic [PIX_W-1:0] pix, input bit typed, input int n,
		input grad_result_t a, input grad_result_t b, input grad_result_t c);
		stim_row_t row;
		row = '0;
		row.kind      = STIM_PIXEL;
		row.data      = CFG_W'(pix);
		row.has_typed = typed;
		row.n_typed   = 2'(n);
		row.typed_res = {c, b, a};
		directed_rows.push_back(row);
	endtask

	// Output monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		grad_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (grad_expected.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: row %0d col %0d grad %0d last %0d",
						out_row, out_col, gradient, last_of_item);
			end else begin
				want = grad_expected.pop_front();
				if (out_row !== want.out_row || out_col !== want.out_col ||
					gradient !== want.gradient || last_of_item !== want.last_of_item) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch row/col/grad/last: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
							want.out_row, want.out_col, want.gradient, want.last_of_item,
							out_row, out_col, gradient, last_of_item);
				end
			end
		end
	end

	// Result side back-pressure
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && rx_stalls_on) stall_left = pick_gap();
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Stimulus
	initial begin
		stim_row_t        row;
		grad_result_t     none;
		logic [CFG_W-1:0] wval;
		logic [CFG_W-1:0] hval;
		int               sel;
		int               wh;
		int               n;
		int               i;

		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = REG_IMAGE_WIDTH;
		cfg_data     = '0;
		in_valid     = 1'b0;
		pixel        = '0;

		for (i = 0; i < MAX_W; i++) begin
			line_above[i]     = '0;
			line_two_above[i] = '0;
		end
		held_pixel = '0;
		cur_row    = 0;
		cur_col    = 0;
		cfg_width  = int'(WIDTH_RESET);
		cfg_height = int'(HEIGHT_RESET);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset geometry: a short run inside the first 640-pixel row gives no results
		for (i = 0; i < 24; i++) send_pixel(random_pixel());
		settle();
		// shrink the frame mid-row, then finish the frame
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		send_frame();

		// Directed 3x3 frames; out-of-range sizes act as the minimum
		none = '0;
		add_cfg(REG_IMAGE_WIDTH, 16'd0);
		add_cfg(REG_IMAGE_HEIGHT, 16'd2);
		// frame with a saturating center: |255-0| + |255-0|
		add_pix(8'd0,   1'b1, 0, none, none, none);
		add_pix(8'd255, 1'b1, 0, none, none, none);
		add_pix(8'd0,   1'b1, 0, none, none, none);
		add_pix(8'd0,   1'b1, 0, none, none, none);
		add_pix(8'd128, 1'b1, 1, res(0, 0, 0, 1), none, none);
		add_pix(8'd255, 1'b1, 2, res(0, 1, 0, 0), res(0, 2, 0, 1), none);
		add_pix(8'd7,   1'b1, 1, res(2, 0, 0, 1), none, none);
		add_pix(8'd0,   1'b1, 2, res(1, 0, 0, 0), res(2, 1, 0, 1), none);
		add_pix(8'd9,   1'b1, 3, res(1, 1, 255, 0), res(1, 2, 0, 0), res(2, 2, 0, 1));
		// flat frame: zero gradient
		for (i = 0; i < 8; i++) add_pix(8'd255, 1'b0, 0, none, none, none);
		add_pix(8'd255, 1'b1, 3, res(1, 1, 0, 0), res(1, 2, 0, 0), res(2, 2, 0, 1));

		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == STIM_CONFIG) begin
				settle();
				write_reg(row.reg_sel, row.data);
			end else begin
				typed_count = row.has_typed ? int'(row.n_typed) : -1;
				typed_results[0] = row.typed_res[0];
				typed_results[1] = row.typed_res[1];
				typed_results[2] = row.typed_res[2];
				send_pixel(row.data[PIX_W-1:0]);
			end
		end

		// Over-range width clamps; a partial first row, then shrink and finish the frame
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		settle();
		write_reg(REG_IMAGE_WIDTH, 16'd2047);
		write_reg(REG_IMAGE_HEIGHT, 16'd0);
		for (i = 0; i < 40; i++) send_pixel(random_pixel());
		settle();
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		send_frame();

		// Tallest frame, cut short by a height write mid-frame
		settle();
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
		for (i = 0; i < 36; i++) send_pixel(random_pixel());
		settle();
		write_reg(REG_IMAGE_HEIGHT, 16'd5);
		send_frame();

		// Random episodes: mostly small frames, occasional resizing mid-frame
		while (random_sent < RANDOM_ITEMS) begin
			tx_gaps_on   = ($urandom_range(0, 3) != 0);
			rx_stalls_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) != 0) begin
				settle();
				sel = $urandom_range(0, 19);
				if (sel == 0) wval = CFG_W'($urandom_range(0, 2));
				else if (sel == 1) wval = CFG_W'($urandom_range(1024, 2047));
				else if (sel <= 3) wval = CFG_W'($urandom_range(13, 64));
				else wval = CFG_W'($urandom_range(3, 12));
				// upper bits are beyond the width register
				if ($urandom_range(0, 3) == 0) wval[CFG_W-1:WCFG_W] = 5'($urandom);
				sel = $urandom_range(0, 19);
				if (sel == 0) hval = CFG_W'($urandom_range(0, 2));
				else if (sel == 1) hval = CFG_W'($urandom_range(9, 40));
				else if (sel == 2) hval = CFG_W'($urandom);
				else hval = CFG_W'($urandom_range(3, 8));
				sel = $urandom_range(0, 2);
				if (sel != 1) write_reg(REG_IMAGE_WIDTH, wval);
				if (sel != 0) write_reg(REG_IMAGE_HEIGHT, hval);
			end
			wh = focus_width() * focus_height();
			n = $urandom_range(1, (2 * wh < 150) ? 2 * wh : 150);
			for (i = 0; i < n; i++) send_pixel(random_pixel());
			random_sent += n;
		end

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fault_count == 0 && grad_expected.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
